>>> src/actuator_i2c_command_framer_core_macros.svh
// assertion macros for the actuator command framer
`ifndef ACTUATOR_I2C_COMMAND_FRAMER_CORE_MACROS_SVH
`define ACTUATOR_I2C_COMMAND_FRAMER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define AICF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("aicf: implication check failed");

// next-cycle implication, checked out of reset
`define AICF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("aicf: next-cycle check failed");

`else

`define AICF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define AICF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> src/aicf_pkg.sv
`default_nettype none

package aicf_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BUS_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_MIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_MAX   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_MAX   = 2'd3;
  localparam int CFG_DATA_W = 16;

  // reset values
  localparam logic [7:0]  RST_BUS_ADDRESS = 8'h80;
  localparam logic [15:0] RST_SERVO_MIN   = 16'd50;
  localparam logic [15:0] RST_SERVO_MAX   = 16'd250;
  localparam logic [15:0] RST_MOTOR_MAX   = 16'd1000;

  // request kinds
  localparam logic [1:0] REQ_SERVO = 2'd0;
  localparam logic [1:0] REQ_MOTOR = 2'd1;
  localparam logic [1:0] REQ_LIGHT = 2'd2;

  // light groups
  localparam logic [1:0] GRP_FRONT   = 2'd0;
  localparam logic [1:0] GRP_AMBIENT = 2'd1;
  localparam logic [1:0] GRP_REAR    = 2'd2;

  // command bytes
  localparam logic [7:0] CMD_MOTOR_INIT   = 8'h01;
  localparam logic [7:0] CMD_FILL         = 8'h00;
  localparam logic [7:0] CMD_FRONT_ON     = 8'h2D;
  localparam logic [7:0] CMD_FRONT_OFF    = 8'h2E;
  localparam logic [7:0] CMD_AMBIENT_ON   = 8'h36;
  localparam logic [7:0] CMD_AMBIENT_OFF  = 8'h37;
  localparam logic [7:0] CMD_REAR_A_ON    = 8'h30;
  localparam logic [7:0] CMD_REAR_A_OFF   = 8'h31;
  localparam logic [7:0] CMD_REAR_B_ON    = 8'h33;
  localparam logic [7:0] CMD_REAR_B_OFF   = 8'h34;

  localparam logic [7:0] SERVO_CMD [4] = '{8'h22, 8'h25, 8'h28, 8'h2B};
  localparam logic [7:0] MOTOR_CMD [4] = '{8'h05, 8'h09, 8'h0D, 8'h11};

  // byte sequencing
  localparam int MAX_BYTES = 12;
  localparam int IDX_W     = $clog2(MAX_BYTES);

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // classified job kinds
  typedef enum logic [2:0] {
    OP_REJECT,
    OP_SERVO,
    OP_MOTOR,
    OP_MOTOR_INIT,
    OP_LIGHT,
    OP_LIGHT2
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  cmd0;
    logic [7:0]  cmd1;
    logic [15:0] val_a;
    logic [15:0] val_b;
  } job_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       stop;
    logic       last;
    logic       status;
  } out_item_t;

  typedef struct packed {
    logic [15:0] servo_min;
    logic [15:0] servo_max;
    logic [15:0] motor_max;
  } limits_t;

  // handshake between queue and a neighbor
  typedef struct packed {
    logic valid;
    logic ready;
  } q_hs_t;

endpackage

`default_nettype wire

>>> src/aicf_front.sv
`default_nettype none

module aicf_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_req_type,
  input  wire logic [7:0]       in_channel,
  input  wire logic [15:0]      in_value_a,
  input  wire logic [15:0]      in_value_b,
  input  wire logic [1:0]       in_light_group,
  input  wire logic             in_light_on,
  input  wire aicf_pkg::limits_t limits,
  input  wire logic             push_ready,
  output aicf_pkg::q_hs_t       push_hs,
  output aicf_pkg::job_t        push_job,
  output logic                  motor_ready
);
  import aicf_pkg::*;

  logic       motor_ready_r;
  logic       motor_ready_nxt;
  logic       ch_ok;
  logic [1:0] ch_sel;
  logic       accept;
  job_t       job;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;

  assign ch_ok  = (in_channel >= 8'd1) && (in_channel <= 8'd4);
  assign ch_sel = in_channel[1:0] - 2'd1;

  always_comb begin
    job       = '0;
    job.op    = OP_REJECT;
    job.val_a = in_value_a;
    job.val_b = in_value_b;
    case (in_req_type)
      REQ_SERVO: begin
        if (ch_ok && (in_value_a >= limits.servo_min) && (in_value_a <= limits.servo_max)) begin
          job.op   = OP_SERVO;
          job.cmd0 = SERVO_CMD[ch_sel];
        end
      end
      REQ_MOTOR: begin
        if (ch_ok && (in_value_a <= limits.motor_max) && (in_value_b <= limits.motor_max)) begin
          job.op   = motor_ready_r ? OP_MOTOR : OP_MOTOR_INIT;
          job.cmd0 = MOTOR_CMD[ch_sel];
        end
      end
      REQ_LIGHT: begin
        case (in_light_group)
          GRP_FRONT: begin
            job.op   = OP_LIGHT;
            job.cmd0 = in_light_on ? CMD_FRONT_ON : CMD_FRONT_OFF;
          end
          GRP_AMBIENT: begin
            job.op   = OP_LIGHT;
            job.cmd0 = in_light_on ? CMD_AMBIENT_ON : CMD_AMBIENT_OFF;
          end
          GRP_REAR: begin
            job.op   = OP_LIGHT2;
            job.cmd0 = in_light_on ? CMD_REAR_A_ON : CMD_REAR_A_OFF;
            job.cmd1 = in_light_on ? CMD_REAR_B_ON : CMD_REAR_B_OFF;
          end
          default: job.op = OP_REJECT;
        endcase
      end
      default: job.op = OP_REJECT;
    endcase
  end

  // init frame goes out once, with the first motor request that passes
  assign motor_ready_nxt = motor_ready_r || (accept && (job.op == OP_MOTOR_INIT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_ready_r <= 1'b0;
    end else begin
      motor_ready_r <= motor_ready_nxt;
    end
  end

  assign push_hs.valid = in_valid;
  assign push_hs.ready = push_ready;
  assign push_job      = job;
  assign motor_ready   = motor_ready_r;

endmodule

`default_nettype wire

>>> src/aicf_queue.sv
`default_nettype none

module aicf_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire aicf_pkg::q_hs_t push_hs,
  input  wire aicf_pkg::job_t  push_job,
  output logic                 push_ready,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output aicf_pkg::job_t       pop_job
);
  import aicf_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];

  assign do_push = push_hs.valid && push_hs.ready;
  assign do_pop  = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/aicf_back.sv
`default_nettype none

module aicf_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [7:0]     bus_address,
  input  wire logic           job_valid,
  input  wire aicf_pkg::job_t job,
  output logic                job_done,
  output logic                out_valid,
  input  wire logic           out_ready,
  output aicf_pkg::out_item_t out_item
);
  import aicf_pkg::*;

  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic [IDX_W-1:0] idx_m3;
  logic [IDX_W-1:0] idx_m6;
  logic             out_valid_r;
  out_item_t        out_item_r;
  out_item_t        item;
  logic             load_ok;
  logic             emit;
  logic             is_long;
  logic [2:0]       pos;
  logic [2:0]       flen;
  logic [7:0]       scmd;
  logic             is_last;

  assign idx_m3 = idx_r - IDX_W'(3);
  assign idx_m6 = idx_r - IDX_W'(6);

  // pick the frame and byte position for this step of the job
  always_comb begin
    is_long = 1'b0;
    pos     = idx_r[2:0];
    flen    = 3'd3;
    scmd    = job.cmd0;
    is_last = 1'b0;
    case (job.op)
      OP_REJECT: begin
        is_last = 1'b1;
      end
      OP_LIGHT: begin
        is_last = (idx_r == IDX_W'(2));
      end
      OP_LIGHT2: begin
        if (idx_r >= IDX_W'(3)) begin
          pos  = idx_m3[2:0];
          scmd = job.cmd1;
        end
        is_last = (idx_r == IDX_W'(5));
      end
      OP_SERVO: begin
        if (idx_r >= IDX_W'(3)) begin
          is_long = 1'b1;
          pos     = idx_m3[2:0];
          flen    = 3'd4;
        end
        is_last = (idx_r == IDX_W'(6));
      end
      OP_MOTOR: begin
        if (idx_r >= IDX_W'(3)) begin
          is_long = 1'b1;
          pos     = idx_m3[2:0];
          flen    = 3'd6;
        end
        is_last = (idx_r == IDX_W'(8));
      end
      OP_MOTOR_INIT: begin
        if (idx_r < IDX_W'(3)) begin
          scmd = CMD_MOTOR_INIT;
        end else if (idx_r < IDX_W'(6)) begin
          pos = idx_m3[2:0];
        end else begin
          is_long = 1'b1;
          pos     = idx_m6[2:0];
          flen    = 3'd6;
        end
        is_last = (idx_r == IDX_W'(MAX_BYTES - 1));
      end
      default: begin
        is_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    item        = '0;
    item.last   = is_last;
    if (job.op == OP_REJECT) begin
      item.status = 1'b1;
    end else begin
      item.start = (pos == 3'd0);
      item.stop  = (pos == flen - 3'd1);
      if (is_long) begin
        case (pos)
          3'd0:    item.data = bus_address;
          3'd1:    item.data = job.cmd0;
          3'd2:    item.data = job.val_a[15:8];
          3'd3:    item.data = job.val_a[7:0];
          3'd4:    item.data = job.val_b[15:8];
          3'd5:    item.data = job.val_b[7:0];
          default: item.data = CMD_FILL;
        endcase
      end else begin
        case (pos)
          3'd0:    item.data = bus_address;
          3'd2:    item.data = scmd;
          default: item.data = CMD_FILL;
        endcase
      end
    end
  end

  assign load_ok  = !out_valid_r || out_ready;
  assign emit     = job_valid && load_ok;
  assign job_done = emit && is_last;
  assign idx_nxt  = job_done ? '0 : (emit ? idx_r + 1'b1 : idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r <= item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

>>> src/actuator_i2c_command_framer_core.sv
`default_nettype none
`include "actuator_i2c_command_framer_core_macros.svh"

// actuator command framer: each accepted request becomes the bytes of its bus
// write frames, one result transaction per byte, with start and stop marks and
// a last flag on the final byte of the request. a rejected request gives one
// transaction with status set and a zero byte. a request yields 1 to 12 bytes
// (12 for the first motor request with its init frame), and the output carries
// one byte per cycle while out_ready stays high. the front takes a new request
// every cycle while the two-entry queue has room, and back-to-back requests
// stream with no gap between them. an accepted request is first written into
// the queue, and its first byte is then registered into the output register.
// configuration is written through cfg_wr_en/cfg_index/cfg_data and must only
// change while idle.
module actuator_i2c_command_framer_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // request channel
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         in_req_type,
  input  wire logic [7:0]                         in_channel,
  input  wire logic [15:0]                        in_value_a,
  input  wire logic [15:0]                        in_value_b,
  input  wire logic [1:0]                         in_light_group,
  input  wire logic                               in_light_on,
  // byte channel
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [7:0]                              out_byte,
  output logic                                    out_frame_start,
  output logic                                    out_frame_stop,
  output logic                                    out_last,
  output logic                                    out_status,
  // configuration writes
  input  wire logic                               cfg_wr_en,
  input  wire logic [aicf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [aicf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import aicf_pkg::*;

  // configuration registers
  logic [7:0]  bus_address_r;
  logic [15:0] servo_min_r;
  logic [15:0] servo_max_r;
  logic [15:0] motor_max_r;
  limits_t     limits;

  // front to queue
  q_hs_t       push_hs;
  job_t        push_job;
  logic        push_ready;
  logic        motor_ready;

  // queue to back
  logic        q_valid;
  job_t        q_job;
  logic        job_done;
  out_item_t   out_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_address_r <= RST_BUS_ADDRESS;
      servo_min_r   <= RST_SERVO_MIN;
      servo_max_r   <= RST_SERVO_MAX;
      motor_max_r   <= RST_MOTOR_MAX;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_BUS_ADDRESS: bus_address_r <= cfg_data[7:0];
        REG_SERVO_MIN:   servo_min_r   <= cfg_data;
        REG_SERVO_MAX:   servo_max_r   <= cfg_data;
        REG_MOTOR_MAX:   motor_max_r   <= cfg_data;
        default:         bus_address_r <= bus_address_r;
      endcase
    end
  end

  assign limits.servo_min = servo_min_r;
  assign limits.servo_max = servo_max_r;
  assign limits.motor_max = motor_max_r;

  // front: range checks and command lookup, tracks the motor init frame
  aicf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_channel     (in_channel),
    .in_value_a     (in_value_a),
    .in_value_b     (in_value_b),
    .in_light_group (in_light_group),
    .in_light_on    (in_light_on),
    .limits         (limits),
    .push_ready     (push_ready),
    .push_hs        (push_hs),
    .push_job       (push_job),
    .motor_ready    (motor_ready)
  );

  // classified jobs wait here so front and back stall independently
  aicf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_hs    (push_hs),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_ready  (job_done),
    .pop_job    (q_job)
  );

  // back: walks the job byte by byte into the output register
  aicf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .bus_address (bus_address_r),
    .job_valid   (q_valid),
    .job         (q_job),
    .job_done    (job_done),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

  assign out_byte        = out_item.data;
  assign out_frame_start = out_item.start;
  assign out_frame_stop  = out_item.stop;
  assign out_last        = out_item.last;
  assign out_status      = out_item.status;

  // an accepted request is always waiting in the queue on the next cycle
  `AICF_ASSERT_NXT(a_accept_queued, clk, rst_n, in_valid && in_ready, q_valid)

  // once the init frame has been scheduled it is never scheduled again
  `AICF_ASSERT_NXT(a_motor_ready_sticky, clk, rst_n, motor_ready, motor_ready)

  // a rejection is a single bare transaction
  `AICF_ASSERT_IMP(a_reject_single, clk, rst_n, out_valid && out_status,
    out_last && !out_frame_start && !out_frame_stop && (out_byte == CMD_FILL))

endmodule

`default_nettype wire
